@@ design/cbg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_pkg: shared types and constants of the candidate box generator
// Widths, configuration layout, queue item layout and the scale factor table.
// ----------------------------------------------------------------------------
package cbg_pkg;

   // coordinate and arithmetic widths
   localparam int COORD_BITS    = 12;
   localparam int SIGNED_BITS   = COORD_BITS + 3;  // candidate coordinates, signed
   localparam int SUM_BITS      = SIGNED_BITS + 1; // corner sums in the range check
   localparam int SCALE_BITS    = 17;              // Q1.16 factor
   localparam int FRAC_BITS     = 16;
   localparam int PROD_BITS     = COORD_BITS + SCALE_BITS;
   localparam int WB_BITS       = PROD_BITS - FRAC_BITS;
   localparam int DELTA_BITS    = 11;              // index times step
   localparam int IDX_BITS      = 5;               // signed loop index -8..8
   localparam int LIM_BITS      = 4;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = COORD_BITS;
   localparam int SSTEP_BITS    = 4;
   localparam int GSTEP_BITS    = 3;
   localparam int OSTEP_BITS    = 5;
   localparam int SIDE_BITS     = 7;
   localparam int SCALE_MAX     = 8;
   localparam int GRID_MAX      = 4;

   localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);
   localparam logic signed [IDX_BITS-1:0] IDX_ONE       = IDX_BITS'(1);
   localparam logic signed [IDX_BITS-1:0] IDX_MINUS_ONE = -IDX_BITS'(1);

   typedef enum logic [1:0] {
      KIND_SCALE  = 2'd0,
      KIND_SHIFT  = 2'd1,
      KIND_ASPECT = 2'd2,
      KIND_NONE   = 2'd3
   } cbg_kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_SCALE_STEPS     = 3'd2,
      CSR_TRANSLATE_STEPS = 3'd3,
      CSR_ASPECT_STEPS    = 3'd4,
      CSR_OFFSET_STEP     = 3'd5,
      CSR_MIN_SIDE        = 3'd6
   } cbg_csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] image_width;
      logic [COORD_BITS-1:0] image_height;
      logic [SSTEP_BITS-1:0] scale_steps;
      logic [GSTEP_BITS-1:0] translate_steps;
      logic [GSTEP_BITS-1:0] aspect_steps;
      logic [OSTEP_BITS-1:0] offset_step;
      logic [SIDE_BITS-1:0]  min_side;
   } cbg_cfg_type;

   typedef struct packed {
      cbg_kind_type          kind;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
      logic [LIM_BITS-1:0]   lim;
   } cbg_item_type;

   // 1.03^(idx-8) in Q1.16, rounded to nearest
   function automatic logic [SCALE_BITS-1:0] scale_factor(input logic [IDX_BITS-1:0] idx);
      logic [SCALE_BITS-1:0] f;
      case (idx)
         5'd0:    f = 17'd51735;
         5'd1:    f = 17'd53287;
         5'd2:    f = 17'd54885;
         5'd3:    f = 17'd56532;
         5'd4:    f = 17'd58228;
         5'd5:    f = 17'd59975;
         5'd6:    f = 17'd61774;
         5'd7:    f = 17'd63627;
         5'd8:    f = 17'd65536;
         5'd9:    f = 17'd67502;
         5'd10:   f = 17'd69527;
         5'd11:   f = 17'd71613;
         5'd12:   f = 17'd73761;
         5'd13:   f = 17'd75974;
         5'd14:   f = 17'd78253;
         5'd15:   f = 17'd80601;
         5'd16:   f = 17'd83019;
         default: f = 17'd65536;
      endcase
      return f;
   endfunction

endpackage

@@ design/cbg_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_csr: configuration registers
// Holds the seven settings; a write lands on valid, unknown indexes drop.
// ----------------------------------------------------------------------------
module cbg_csr
   import cbg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cbg_cfg_type              cfg
);

   cbg_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (cbg_csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:     cfg_in.image_width     = csr_wdata[COORD_BITS-1:0];
            CSR_IMAGE_HEIGHT:    cfg_in.image_height    = csr_wdata[COORD_BITS-1:0];
            CSR_SCALE_STEPS:     cfg_in.scale_steps     = csr_wdata[SSTEP_BITS-1:0];
            CSR_TRANSLATE_STEPS: cfg_in.translate_steps = csr_wdata[GSTEP_BITS-1:0];
            CSR_ASPECT_STEPS:    cfg_in.aspect_steps    = csr_wdata[GSTEP_BITS-1:0];
            CSR_OFFSET_STEP:     cfg_in.offset_step     = csr_wdata[OSTEP_BITS-1:0];
            CSR_MIN_SIDE:        cfg_in.min_side        = csr_wdata[SIDE_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= COORD_BITS'(640);
         cfg_ff.image_height    <= COORD_BITS'(480);
         cfg_ff.scale_steps     <= SSTEP_BITS'(8);
         cfg_ff.translate_steps <= GSTEP_BITS'(4);
         cfg_ff.aspect_steps    <= GSTEP_BITS'(3);
         cfg_ff.offset_step     <= OSTEP_BITS'(2);
         cfg_ff.min_side        <= SIDE_BITS'(16);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/cbg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_front: request intake and classification
// Clamps the loop range per kind, drops requests that yield nothing and
// queues the rest for the back end.
// ----------------------------------------------------------------------------
module cbg_front
   import cbg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cbg_cfg_type           cfg,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_kind,
   input  logic [COORD_BITS-1:0] req_box_x,
   input  logic [COORD_BITS-1:0] req_box_y,
   input  logic [COORD_BITS-1:0] req_box_w,
   input  logic [COORD_BITS-1:0] req_box_h,
   output logic                  q_valid,
   output cbg_item_type          q_item,
   input  logic                  q_pop
);

   localparam int QDEPTH   = 4;
   localparam int PTR_BITS = $clog2(QDEPTH);
   localparam int CNT_BITS = $clog2(QDEPTH + 1);

   cbg_item_type                queue_ff [QDEPTH];
   logic [PTR_BITS-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   cbg_item_type                item;
   logic                        useful;
   logic                        push;

   // classify the request and clamp its loop range
   always_comb begin
      item.kind = cbg_kind_type'(req_kind);
      item.x    = req_box_x;
      item.y    = req_box_y;
      item.w    = req_box_w;
      item.h    = req_box_h;
      item.lim  = '0;
      useful    = 1'b0;
      case (item.kind)
         KIND_SCALE: begin
            item.lim = (LIM_BITS'(cfg.scale_steps) > LIM_BITS'(SCALE_MAX)) ?
                       LIM_BITS'(SCALE_MAX) : LIM_BITS'(cfg.scale_steps);
            useful   = 1'b1;
         end
         KIND_SHIFT: begin
            item.lim = (LIM_BITS'(cfg.translate_steps) > LIM_BITS'(GRID_MAX)) ?
                       LIM_BITS'(GRID_MAX) : LIM_BITS'(cfg.translate_steps);
            useful   = (item.lim != '0);
         end
         KIND_ASPECT: begin
            item.lim = (LIM_BITS'(cfg.aspect_steps) > LIM_BITS'(GRID_MAX)) ?
                       LIM_BITS'(GRID_MAX) : LIM_BITS'(cfg.aspect_steps);
            useful   = (item.lim != '0);
         end
         default: begin
            item.lim = '0;
            useful   = 1'b0;
         end
      endcase
   end

   assign busy    = (count_ff == CNT_BITS'(QDEPTH));
   assign push    = start && !busy && useful;
   assign q_valid = (count_ff != '0);
   assign q_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push) - CNT_BITS'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

@@ design/cbg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_back: candidate sequencer and datapath
// Walks the index loops one candidate per cycle, scales or shifts the box,
// range checks it and holds one kept candidate back to mark the last one.
// ----------------------------------------------------------------------------
module cbg_back
   import cbg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cbg_cfg_type           cfg,
   input  logic                  q_valid,
   input  cbg_item_type          q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output logic [COORD_BITS-1:0] rsp_cand_x,
   output logic [COORD_BITS-1:0] rsp_cand_y,
   output logic [COORD_BITS-1:0] rsp_cand_w,
   output logic [COORD_BITS-1:0] rsp_cand_h,
   output logic                  rsp_last
);

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_REF,
      SEQ_SWEEP
   } seq_state_type;

   // sequencer
   seq_state_type               state_ff, state_in;
   cbg_item_type                item_ff, item_in;
   logic signed [IDX_BITS-1:0]  i_ff, i_in, j_ff, j_in;
   logic signed [IDX_BITS-1:0]  lim_s, neg_lim, load_lim, i_adv, j_adv;
   logic                        tok_valid, tok_end, tok_ref;

   // product stage
   logic [IDX_BITS-1:0]           sidx;
   logic [SCALE_BITS-1:0]         sfac;
   logic [PROD_BITS-1:0]          pw_in, ph_in;
   logic signed [DELTA_BITS-1:0]  di_in, dj_in, step_s;
   logic                          p_valid_ff, p_end_ff, p_ref_ff;
   cbg_kind_type                  p_kind_ff;
   logic [COORD_BITS-1:0]         p_x_ff, p_y_ff, p_w_ff, p_h_ff;
   logic [PROD_BITS-1:0]          p_pw_ff, p_ph_ff;
   logic signed [DELTA_BITS-1:0]  p_di_ff, p_dj_ff;

   // candidate stage
   logic signed [SIGNED_BITS-1:0] cx, cy, aw, ah, half_aw, half_ah;
   logic [PROD_BITS-1:0]          sum_w, sum_h;
   logic [WB_BITS-1:0]            wb, hb;
   logic signed [SIGNED_BITS-1:0] c_x, c_y, c_w, c_h;
   logic                          s_valid_ff, s_end_ff, s_ref_ff;
   logic signed [SIGNED_BITS-1:0] s_x_ff, s_y_ff, s_w_ff, s_h_ff;

   // check and hold-back stage
   logic [SIDE_BITS-1:0]          ms;
   logic signed [SUM_BITS-1:0]    xs, ys, ws, hs, xe, ye, iw, ih, mss;
   logic                          in_range, keep, fire, fire_last;
   logic                          pend_valid_ff, pend_valid_in, pend_final_ff, pend_final_in;
   logic [COORD_BITS-1:0]         pend_x_ff, pend_y_ff, pend_w_ff, pend_h_ff;
   logic                          rsp_valid_ff, rsp_last_ff;
   logic [COORD_BITS-1:0]         rsp_x_ff, rsp_y_ff, rsp_w_ff, rsp_h_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      lim_s     = $signed({1'b0, item_ff.lim});
      neg_lim   = -lim_s;
      load_lim  = -$signed({1'b0, q_item.lim});
      i_adv     = (i_ff == IDX_MINUS_ONE) ? IDX_ONE : i_ff + IDX_ONE;
      j_adv     = (j_ff == IDX_MINUS_ONE) ? IDX_ONE : j_ff + IDX_ONE;
      tok_valid = (state_ff != SEQ_IDLE);
      tok_ref   = (state_ff == SEQ_REF);
      case (state_ff)
         SEQ_REF:   tok_end = (item_ff.lim == '0);
         SEQ_SWEEP: tok_end = (item_ff.kind == KIND_SCALE) ? (i_ff == lim_s) :
                              ((i_ff == lim_s) && (j_ff == lim_s));
         default:   tok_end = 1'b0;
      endcase
      q_pop = q_valid && (!tok_valid || tok_end);

      state_in = state_ff;
      item_in  = item_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      if (q_pop) begin
         item_in  = q_item;
         i_in     = load_lim;
         j_in     = load_lim;
         state_in = (q_item.kind == KIND_SCALE) ? SEQ_REF : SEQ_SWEEP;
      end else if (tok_end) begin
         state_in = SEQ_IDLE;
      end else begin
         case (state_ff)
            SEQ_REF: state_in = SEQ_SWEEP;
            SEQ_SWEEP: begin
               if (item_ff.kind == KIND_SCALE) begin
                  i_in = i_adv;
               end else if (j_ff == lim_s) begin
                  j_in = neg_lim;
                  i_in = i_adv;
               end else begin
                  j_in = j_adv;
               end
            end
            default: state_in = SEQ_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff <= item_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
   end

   // ---------------- products ----------------
   always_comb begin
      sidx   = $unsigned(i_ff) + IDX_BITS'(SCALE_MAX);
      sfac   = scale_factor(sidx);
      pw_in  = PROD_BITS'(item_ff.w) * PROD_BITS'(sfac);
      ph_in  = PROD_BITS'(item_ff.h) * PROD_BITS'(sfac);
      step_s = DELTA_BITS'($signed({1'b0, cfg.offset_step}));
      di_in  = DELTA_BITS'(i_ff) * step_s;
      dj_in  = DELTA_BITS'(j_ff) * step_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= tok_valid;
      end
      p_end_ff  <= tok_end;
      p_ref_ff  <= tok_ref;
      p_kind_ff <= item_ff.kind;
      p_x_ff    <= item_ff.x;
      p_y_ff    <= item_ff.y;
      p_w_ff    <= item_ff.w;
      p_h_ff    <= item_ff.h;
      p_pw_ff   <= pw_in;
      p_ph_ff   <= ph_in;
      p_di_ff   <= di_in;
      p_dj_ff   <= dj_in;
   end

   // ---------------- candidate ----------------
   always_comb begin
      cx      = $signed(SIGNED_BITS'(p_x_ff)) + $signed(SIGNED_BITS'(p_w_ff >> 1));
      cy      = $signed(SIGNED_BITS'(p_y_ff)) + $signed(SIGNED_BITS'(p_h_ff >> 1));
      sum_w   = p_pw_ff + ROUND_HALF;
      sum_h   = p_ph_ff + ROUND_HALF;
      wb      = sum_w[PROD_BITS-1:FRAC_BITS];
      hb      = sum_h[PROD_BITS-1:FRAC_BITS];
      aw      = $signed(SIGNED_BITS'(p_w_ff)) + SIGNED_BITS'(p_di_ff);
      ah      = $signed(SIGNED_BITS'(p_h_ff)) + SIGNED_BITS'(p_dj_ff);
      // halve toward zero
      half_aw = (aw + $signed(SIGNED_BITS'(aw[SIGNED_BITS-1]))) >>> 1;
      half_ah = (ah + $signed(SIGNED_BITS'(ah[SIGNED_BITS-1]))) >>> 1;

      c_x = $signed(SIGNED_BITS'(p_x_ff));
      c_y = $signed(SIGNED_BITS'(p_y_ff));
      c_w = $signed(SIGNED_BITS'(p_w_ff));
      c_h = $signed(SIGNED_BITS'(p_h_ff));
      if (!p_ref_ff) begin
         case (p_kind_ff)
            KIND_SCALE: begin
               c_x = cx - $signed(SIGNED_BITS'(wb >> 1));
               c_y = cy - $signed(SIGNED_BITS'(hb >> 1));
               c_w = $signed(SIGNED_BITS'(wb));
               c_h = $signed(SIGNED_BITS'(hb));
            end
            KIND_SHIFT: begin
               c_x = $signed(SIGNED_BITS'(p_x_ff)) + SIGNED_BITS'(p_di_ff);
               c_y = $signed(SIGNED_BITS'(p_y_ff)) + SIGNED_BITS'(p_dj_ff);
            end
            KIND_ASPECT: begin
               c_x = cx - half_aw;
               c_y = cy - half_ah;
               c_w = aw;
               c_h = ah;
            end
            default: begin
               c_x = $signed(SIGNED_BITS'(p_x_ff));
               c_y = $signed(SIGNED_BITS'(p_y_ff));
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= p_valid_ff;
      end
      s_end_ff <= p_end_ff;
      s_ref_ff <= p_ref_ff;
      s_x_ff   <= c_x;
      s_y_ff   <= c_y;
      s_w_ff   <= c_w;
      s_h_ff   <= c_h;
   end

   // ---------------- range check and hold-back ----------------
   always_comb begin
      ms       = (cfg.min_side == '0) ? SIDE_BITS'(1) : cfg.min_side;
      mss      = $signed(SUM_BITS'(ms));
      iw       = $signed(SUM_BITS'(cfg.image_width));
      ih       = $signed(SUM_BITS'(cfg.image_height));
      xs       = SUM_BITS'(s_x_ff);
      ys       = SUM_BITS'(s_y_ff);
      ws       = SUM_BITS'(s_w_ff);
      hs       = SUM_BITS'(s_h_ff);
      xe       = xs + ws;
      ye       = ys + hs;
      in_range = (xs >= 0) && (ys >= 0) && (xs < iw) && (ys < ih) &&
                 (xe >= 0) && (ye >= 0) && (xe < iw) && (ye < ih) &&
                 (ws >= mss) && (hs >= mss);
      keep     = s_valid_ff && (s_ref_ff || in_range);

      // release the held candidate once its successor or the item end shows up
      fire      = pend_valid_ff && (pend_final_ff || keep || (s_valid_ff && s_end_ff));
      fire_last = pend_final_ff || (s_valid_ff && s_end_ff && !keep);

      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      if (keep) begin
         pend_valid_in = 1'b1;
         pend_final_in = s_end_ff;
      end else if (fire) begin
         pend_valid_in = 1'b0;
         pend_final_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in;
         rsp_valid_ff  <= fire;
      end
      if (keep) begin
         pend_x_ff <= s_x_ff[COORD_BITS-1:0];
         pend_y_ff <= s_y_ff[COORD_BITS-1:0];
         pend_w_ff <= s_w_ff[COORD_BITS-1:0];
         pend_h_ff <= s_h_ff[COORD_BITS-1:0];
      end
      rsp_last_ff <= fire_last;
      rsp_x_ff    <= pend_x_ff;
      rsp_y_ff    <= pend_y_ff;
      rsp_w_ff    <= pend_w_ff;
      rsp_h_ff    <= pend_h_ff;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_cand_x = rsp_x_ff;
   assign rsp_cand_y = rsp_y_ff;
   assign rsp_cand_w = rsp_w_ff;
   assign rsp_cand_h = rsp_h_ff;

   // ---------------- assertions ----------------
   a_final_held: assert property (@(posedge clock) disable iff (reset)
      pend_final_ff |-> pend_valid_ff)
      else $error("final candidate marked with nothing held");

   a_end_kept: assert property (@(posedge clock) disable iff (reset)
      (s_valid_ff && s_end_ff && keep) |=> (pend_valid_ff && pend_final_ff))
      else $error("kept end candidate not held as final");

   a_scale_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SWEEP && item_ff.kind == KIND_SCALE) |-> (i_ff != '0))
      else $error("scale sweep reached the unit factor");

   a_grid_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SWEEP && item_ff.kind != KIND_SCALE) |->
      ((i_ff != '0) && (j_ff != '0)))
      else $error("grid sweep reached a zero index");

endmodule

@@ design/candidate_box_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// candidate_box_generator_core: candidate box generator
// Emits scaled, shifted or reshaped boxes around a reference box, keeping only
// those inside the image and not below the minimum side, or a scale reference.
// ----------------------------------------------------------------------------
// A request (start high while busy is low) carries a kind and a reference box.
// The front end clamps the loop range and drops requests that cannot yield a
// candidate (unused kind, zero translation or aspect range); the rest wait in
// a four-entry queue, and busy is high only while that queue is full. The back
// end sequencer issues one candidate per clock: 1 + 2n for the scale kind
// (the reference box, then n factors each side), 4t*t for translation and
// aspect, at most 64 per request. Candidates pass a product stage, a
// coordinate stage and a range check; one kept candidate is held back so the
// final one can carry rsp_last. A kept candidate passes the product,
// candidate, hold-back and result registers on its way to the result ports,
// and waits in the hold-back register while the next kept candidate or the
// end of its request is still on the way.
// Results leave as single-cycle strobes on rsp_valid: the receiver cannot
// stall, so every strobe must be taken. Rejected candidates leave gaps in the
// stream. Write configuration only while no request is in flight.
// ----------------------------------------------------------------------------
module candidate_box_generator_core
   import cbg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_kind,
   input  logic [COORD_BITS-1:0]    req_box_x,
   input  logic [COORD_BITS-1:0]    req_box_y,
   input  logic [COORD_BITS-1:0]    req_box_w,
   input  logic [COORD_BITS-1:0]    req_box_h,
   // result channel
   output logic                     rsp_valid,
   output logic [COORD_BITS-1:0]    rsp_cand_x,
   output logic [COORD_BITS-1:0]    rsp_cand_y,
   output logic [COORD_BITS-1:0]    rsp_cand_w,
   output logic [COORD_BITS-1:0]    rsp_cand_h,
   output logic                     rsp_last,
   // configuration write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cbg_cfg_type  cfg;
   logic         q_valid;
   logic         q_pop;
   cbg_item_type q_item;

   // hold the settings
   cbg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // accept and classify requests, queue them for the back end
   cbg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .start     (start),
      .busy      (busy),
      .req_kind  (req_kind),
      .req_box_x (req_box_x),
      .req_box_y (req_box_y),
      .req_box_w (req_box_w),
      .req_box_h (req_box_h),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // sweep the candidates and stream out the kept ones
   cbg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_cand_x (rsp_cand_x),
      .rsp_cand_y (rsp_cand_y),
      .rsp_cand_w (rsp_cand_w),
      .rsp_cand_h (rsp_cand_h),
      .rsp_last   (rsp_last)
   );

endmodule
